@@ design/assert_macros.svh @@
// assertion macros used by the sprite quad setup rtl
// no dependencies; SYNTH builds see empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SQVS_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sqvs assertion failed");
`define SQVS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sqvs assertion failed");
`else
`define SQVS_ASSERT(lbl, clk, rst, prop)
`define SQVS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ design/sqvs_pkg.sv @@
// types, constants and helper functions of the sprite quad vertex setup
// no dependencies
package sqvs_pkg;

  localparam int VERTS_PER_QUAD = 6;
  localparam int CORDIC_ITERS   = 30;
  localparam int ADDR_W         = 5;

  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
  localparam logic [16:0]        TEX_ONE   = 17'h10000;

  // register indexes
  localparam logic [2:0] REG_SHEET_W = 3'd0;
  localparam logic [2:0] REG_SHEET_H = 3'd1;
  localparam logic [2:0] REG_CELL_W  = 3'd2;
  localparam logic [2:0] REG_CELL_H  = 3'd3;
  localparam logic [2:0] REG_FRAMES  = 3'd4;
  localparam logic [2:0] REG_COLS    = 3'd5;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] depth_in;
    logic [15:0]        scale_factor;
    logic [15:0]        angle;
    logic [15:0]        frame_index;
  } req_t;

  typedef struct packed {
    logic signed [23:0] vert_x;
    logic signed [23:0] vert_y;
    logic signed [15:0] vert_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               last_vertex;
  } vtx_t;

  // effective register values
  typedef struct packed {
    logic [12:0] sheet_width;
    logic [12:0] sheet_height;
    logic [12:0] cell_width;
    logic [12:0] cell_height;
    logic [10:0] frame_total;
    logic [10:0] column_total;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       commit;
    logic       grab;
    logic       tex_start;
    logic       tex_store;
    logic       mult;
    logic       corner;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cordic_busy;
    logic skip;
  } stat_t;

  function automatic logic [29:0] atan_val(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // corner of each output vertex: 0 tl, 1 tr, 2 bl, 3 br
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] r;
    unique case (k)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd3;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ design/sprite_quad_vertex_setup.sv @@
// One request at a time: the input stalls from acceptance until the last vertex is taken,
// or until a repeated request is dropped after the frame modulo and repeat check.
// Steps: frame modulo, repeat check, column/row, four texture divisions on one shared
// radix-2 divider (cordic overlaps), cordic wait, four multiplies, four corners, then
// six vertices, each held while the output stalls. Reset (rst, sync): registers 1,
// no previous, idle.
module sprite_quad_vertex_setup import sqvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req,
  output logic              vtx_valid,
  input  logic              vtx_stall,
  output vtx_t              vtx,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  sqvs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sqvs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_stall  (req_stall),
    .out_valid (vtx_valid),
    .out_stall (vtx_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sqvs_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .cfg  (cfg),
    .cmd  (cmd),
    .stat (stat),
    .vtx  (vtx)
  );

endmodule

@@ design/sqvs_regs.sv @@
// apb configuration registers with effective-value clamping
// depends on sqvs_pkg
module sqvs_regs import sqvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [12:0] sheet_w, sheet_h, cell_w, cell_h;
  logic [10:0] frames, cols;
  logic [2:0]  ridx;

  assign ridx   = paddr[4:2];
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sheet_w <= 13'd1;
      sheet_h <= 13'd1;
      cell_w  <= 13'd1;
      cell_h  <= 13'd1;
      frames  <= 11'd1;
      cols    <= 11'd1;
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_SHEET_W: sheet_w <= pwdata[12:0];
        REG_SHEET_H: sheet_h <= pwdata[12:0];
        REG_CELL_W:  cell_w  <= pwdata[12:0];
        REG_CELL_H:  cell_h  <= pwdata[12:0];
        REG_FRAMES:  frames  <= pwdata[10:0];
        REG_COLS:    cols    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (ridx)
      REG_SHEET_W: prdata = {19'd0, sheet_w};
      REG_SHEET_H: prdata = {19'd0, sheet_h};
      REG_CELL_W:  prdata = {19'd0, cell_w};
      REG_CELL_H:  prdata = {19'd0, cell_h};
      REG_FRAMES:  prdata = {21'd0, frames};
      REG_COLS:    prdata = {21'd0, cols};
      default:     prdata = 32'd0;
    endcase
  end

  // zero acts as one, counts cap at 1024
  always_comb begin
    cfg.sheet_width  = (sheet_w == 13'd0) ? 13'd1 : sheet_w;
    cfg.sheet_height = (sheet_h == 13'd0) ? 13'd1 : sheet_h;
    cfg.cell_width   = (cell_w == 13'd0) ? 13'd1 : cell_w;
    cfg.cell_height  = (cell_h == 13'd0) ? 13'd1 : cell_h;
    cfg.frame_total  = (frames == 11'd0) ? 11'd1 :
                       (frames > 11'd1024) ? 11'd1024 : frames;
    cfg.column_total = (cols == 11'd0) ? 11'd1 :
                       (cols > 11'd1024) ? 11'd1024 : cols;
  end

endmodule

@@ design/sqvs_div.sv @@
// restoring divider, one quotient bit per cycle
// depends on sqvs_pkg
module sqvs_div import sqvs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [12:0] rem_init,
  input  logic [15:0] num,
  input  logic [12:0] den,
  output logic        busy,
  output logic [15:0] quo,
  output logic [12:0] rem
);

  logic [12:0] den_q;
  logic [4:0]  steps;
  logic [13:0] trial;
  logic        take;

  assign trial = {rem, quo[15]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= 5'd0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= 5'd16;
    end else if (busy) begin
      steps <= steps - 5'd1;
      if (steps == 5'd1) busy <= 1'b0;
    end
  end

  // shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      rem <= take ? 13'(trial - {1'b0, den_q}) : trial[12:0];
      quo <= {quo[14:0], take};
    end
  end

endmodule

@@ design/sqvs_cordic.sv @@
// iterative cordic, one rotation per cycle, cos and sin in q1.30
// depends on sqvs_pkg for the arctangent table
module sqvs_cordic import sqvs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               busy,
  output logic signed [31:0] cos_v,
  output logic signed [31:0] sin_v
);

  logic signed [32:0] x, y, dx, dy, xn, yn;
  logic signed [31:0] z, at;
  logic [4:0]         i;
  logic               neg;

  assign dx = y >>> i;
  assign dy = x >>> i;
  assign at = 32'($signed({2'b00, atan_val(i)}));
  assign xn = z[31] ? x + dx : x - dx;
  assign yn = z[31] ? y - dy : y + dy;
  assign cos_v = x[31:0];
  assign sin_v = y[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i    <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      i    <= 5'd0;
    end else if (busy) begin
      i <= i + 5'd1;
      if (i == 5'(CORDIC_ITERS - 1)) busy <= 1'b0;
    end
  end

  // half-turn fold at start, rotate, undo fold on last step
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= angle[15] ^ angle[14];
      z   <= $signed({angle[15] ^ (angle[15] ^ angle[14]), angle[14:0], 16'd0});
      x   <= CORDIC_X0;
      y   <= 33'sd0;
    end else if (busy) begin
      z <= z[31] ? z + at : z - at;
      if (i == 5'(CORDIC_ITERS - 1) && neg) begin
        x <= -xn;
        y <= -yn;
      end else begin
        x <= xn;
        y <= yn;
      end
    end
  end

endmodule

@@ design/sqvs_dp.sv @@
// datapath: request capture, repeat check, texture and corner math, output mux
// depends on sqvs_pkg, sqvs_div, sqvs_cordic
module sqvs_dp import sqvs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cfg_t cfg,
  input  cmd_t cmd,
  output stat_t stat,
  output vtx_t vtx
);

  req_t               rq;
  logic               anim;
  logic [12:0]        h_sel;
  logic [28:0]        hx, hy;
  logic [9:0]         col, row;
  logic [16:0]        tex [4];
  logic               sat;
  logic signed [61:0] prod [4];
  logic signed [23:0] cx [4];
  logic signed [23:0] cy [4];

  logic        have_previous;
  logic [15:0] last_int_x, last_int_y, last_angle, last_scale;
  logic [9:0]  last_frame;

  logic        div_start, div_busy;
  logic [12:0] div_rem0, div_den, div_rem;
  logic [15:0] div_num, div_quo;
  logic        cor_busy;
  logic signed [31:0] cos_v, sin_v;

  logic        anim_n;
  logic [12:0] cell_len, sheet;
  logic [10:0] tidx;
  logic [23:0] tnum;
  logic [15:0] ix, iy;

  function automatic logic [15:0] trunc_int(input logic signed [23:0] p);
    logic [24:0] m;
    logic [15:0] t;
    m = 25'(-$signed({p[23], p}));
    t = m[23:8];
    return p[23] ? 16'(16'd0 - t) : p[23:8];
  endfunction

  function automatic logic signed [23:0] place(input logic signed [63:0] sum,
                                               input logic signed [23:0] pos);
    logic signed [63:0] sh;
    logic signed [39:0] r;
    sh = (sum + 64'sd1073741824) >>> 31;
    r  = sh[39:0] + 40'(pos);
    if (r > 40'sd8388607) return 24'sh7FFFFF;
    if (r < -40'sd8388608) return 24'sh800000;
    return r[23:0];
  endfunction

  assign anim_n = cfg.frame_total > 11'd1;

  // texture division operands for the current edge
  always_comb begin
    cell_len = cmd.idx[1] ? cfg.cell_height : cfg.cell_width;
    sheet    = cmd.idx[1] ? cfg.sheet_height : cfg.sheet_width;
    tidx     = {1'b0, cmd.idx[1] ? row : col} + {10'd0, cmd.idx[0]};
    tnum     = cell_len * tidx;
  end

  // divider operand select
  always_comb begin
    div_start = cmd.load | cmd.commit | cmd.tex_start;
    div_rem0  = 13'd0;
    div_num   = req.frame_index;
    div_den   = {2'b00, cfg.frame_total};
    if (cmd.commit) begin
      div_num = {6'd0, div_rem[9:0]};
      div_den = {2'b00, cfg.column_total};
    end else if (cmd.tex_start) begin
      div_rem0 = tnum[12:0];
      div_num  = 16'd0;
      div_den  = sheet;
    end
  end

  sqvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem0),
    .num      (div_num),
    .den      (div_den),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  sqvs_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.commit),
    .angle (rq.angle),
    .busy  (cor_busy),
    .cos_v (cos_v),
    .sin_v (sin_v)
  );

  // repeat check against the last emitted request
  assign ix = trunc_int(rq.pos_x);
  assign iy = trunc_int(rq.pos_y);
  assign stat.div_busy    = div_busy;
  assign stat.cordic_busy = cor_busy;
  assign stat.skip = have_previous && ix == last_int_x && iy == last_int_y &&
                     rq.angle == last_angle && rq.scale_factor == last_scale &&
                     (!anim || div_rem[9:0] == last_frame);

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      last_int_x    <= 16'hFFFF;
      last_int_y    <= 16'hFFFF;
      last_angle    <= 16'd0;
      last_scale    <= 16'd0;
      last_frame    <= 10'd0;
    end else if (cmd.commit) begin
      have_previous <= 1'b1;
      last_int_x    <= ix;
      last_int_y    <= iy;
      last_angle    <= rq.angle;
      last_scale    <= rq.scale_factor;
      if (anim) last_frame <= div_rem[9:0];
    end
  end

  // request capture, half sizes, cell position, texture results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq    <= req;
      anim  <= anim_n;
      hx    <= (anim_n ? cfg.cell_width : cfg.sheet_width) * req.scale_factor;
      h_sel <= anim_n ? cfg.cell_height : cfg.sheet_height;
    end
    if (cmd.commit) begin
      hy <= h_sel * rq.scale_factor;
    end
    if (cmd.grab) begin
      col <= div_rem[9:0];
      row <= div_quo[9:0];
    end
    if (cmd.tex_start) sat <= tnum >= {11'd0, sheet};
    if (cmd.tex_store) tex[cmd.idx[1:0]] <= sat ? TEX_ONE : {1'b0, div_quo};
  end

  // products: hx*c, hy*s, hx*s, hy*c
  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      prod[cmd.idx[1:0]] <=
        $signed({1'b0, (cmd.idx[1:0] == 2'd0 || cmd.idx[1:0] == 2'd2) ? hx : hy}) *
        ((cmd.idx[1:0] == 2'd0 || cmd.idx[1:0] == 2'd3) ? cos_v : sin_v);
    end
  end

  // one corner per cycle: rotate, round, translate, saturate
  always_ff @(posedge clk) begin
    logic signed [63:0] p0, p1, p2, p3;
    p0 = 64'(prod[0]);
    p1 = 64'(prod[1]);
    p2 = 64'(prod[2]);
    p3 = 64'(prod[3]);
    if (cmd.corner) begin
      cx[cmd.idx[1:0]] <= place((cmd.idx[0] ? p0 : -p0) + (cmd.idx[1] ? p1 : -p1),
                                rq.pos_x);
      cy[cmd.idx[1:0]] <= place((cmd.idx[0] ? p2 : -p2) + (cmd.idx[1] ? -p3 : p3),
                                rq.pos_y);
    end
  end

  // vertex output mux
  always_comb begin
    logic [1:0] p;
    p = corner_of(cmd.idx);
    vtx.vert_x      = cx[p];
    vtx.vert_y      = cy[p];
    vtx.vert_z      = rq.depth_in;
    vtx.tex_u       = anim ? tex[{1'b0, p[0]}] : (p[0] ? TEX_ONE : 17'd0);
    vtx.tex_v       = anim ? tex[{1'b1, p[1]}] : (p[1] ? TEX_ONE : 17'd0);
    vtx.last_vertex = cmd.idx == 3'(VERTS_PER_QUAD - 1);
  end

endmodule

@@ design/sqvs_ctrl.sv @@
// controller state machine sequencing the datapath for one request
// depends on sqvs_pkg and assert_macros.svh
`include "assert_macros.svh"
module sqvs_ctrl import sqvs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_MODF   = 10'b0000000010,
    ST_CHECK  = 10'b0000000100,
    ST_COLROW = 10'b0000001000,
    ST_TEXS   = 10'b0000010000,
    ST_TEXW   = 10'b0000100000,
    ST_CWAIT  = 10'b0001000000,
    ST_MULT   = 10'b0010000000,
    ST_CORNER = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;

  assign in_stall  = state != ST_IDLE;
  assign out_valid = state == ST_EMIT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 3'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.idx    = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MODF;
        end
      end
      ST_MODF: begin
        if (!stat.div_busy) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.skip) begin
          state_next = ST_IDLE;
        end else begin
          cmd.commit = 1'b1;
          state_next = ST_COLROW;
        end
      end
      ST_COLROW: begin
        if (!stat.div_busy) begin
          cmd.grab   = 1'b1;
          cnt_next   = 3'd0;
          state_next = ST_TEXS;
        end
      end
      ST_TEXS: begin
        cmd.tex_start = 1'b1;
        state_next    = ST_TEXW;
      end
      ST_TEXW: begin
        if (!stat.div_busy) begin
          cmd.tex_store = 1'b1;
          if (cnt == 3'd3) begin
            cnt_next   = 3'd0;
            state_next = ST_CWAIT;
          end else begin
            cnt_next   = cnt + 3'd1;
            state_next = ST_TEXS;
          end
        end
      end
      ST_CWAIT: begin
        if (!stat.cordic_busy) state_next = ST_MULT;
      end
      ST_MULT: begin
        cmd.mult = 1'b1;
        if (cnt == 3'd3) begin
          cnt_next   = 3'd0;
          state_next = ST_CORNER;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_CORNER: begin
        cmd.corner = 1'b1;
        if (cnt == 3'd3) begin
          cnt_next   = 3'd0;
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + 3'd1;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          if (cnt == 3'(VERTS_PER_QUAD - 1)) begin
            cnt_next   = 3'd0;
            state_next = ST_IDLE;
          end else begin
            cnt_next = cnt + 3'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `SQVS_ASSERT(a_no_req_while_out, clk, rst, out_valid |-> in_stall)
  `SQVS_ASSERT(a_accept_starts_mod, clk, rst, (in_valid && !in_stall) |=> (state == ST_MODF))
  `SQVS_ASSERT(a_last_ends_quad, clk, rst, (out_valid && !out_stall && cnt == 3'd5) |=> !out_valid)
  `SQVS_ASSERT(a_vertex_in_range, clk, rst, out_valid |-> (cnt <= 3'd5))

endmodule

@@ verif/tb_sprite_quad_vertex_setup.sv @@
// testbench for sprite_quad_vertex_setup: draw requests in, six vertices out
// depends on sqvs_pkg and the rtl; a scoreboard class predicts each vertex
module tb_sprite_quad_vertex_setup;
  timeunit 1ns;
  timeprecision 1ps;
  import sqvs_pkg::*;

  // expected vertices of each emitting request, checked in order
  class quad_scoreboard;
    vtx_t pending_vtx[$];
    int errors;
    logic [12:0] sheet_w, sheet_h, cell_w, cell_h;
    logic [10:0] frames, cols;
    bit have_prev;
    logic [15:0] prev_ix, prev_iy, prev_angle, prev_scale;
    logic [9:0] prev_frame;

    function void clear();
      sheet_w = 1; sheet_h = 1; cell_w = 1; cell_h = 1; frames = 1; cols = 1;
      have_prev = 0; prev_ix = 16'hFFFF; prev_iy = 16'hFFFF;
      prev_angle = 0; prev_scale = 0; prev_frame = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_SHEET_W: sheet_w = d[12:0];
        REG_SHEET_H: sheet_h = d[12:0];
        REG_CELL_W:  cell_w = d[12:0];
        REG_CELL_H:  cell_h = d[12:0];
        REG_FRAMES:  frames = d[10:0];
        REG_COLS:    cols = d[10:0];
        default: ;
      endcase
    endfunction

    // arithmetic shift toward minus infinity
    function longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    function void rotate(logic [15:0] ang, output longint c, output longint s);
      logic [31:0] t;
      logic [1:0] q;
      bit flip;
      longint x, y, z, dx, dy;
      t = {ang, 16'h0};
      q = t[31:30];
      flip = 0;
      x = 652032874; y = 0;
      if (q == 1 || q == 2) begin
        t = t + 32'h8000_0000;
        flip = 1;
      end
      z = t[31] ? longint'(t) - (longint'(1) << 32) : longint'(t);
      for (int i = 0; i < 30; i++) begin
        dx = floor_shift(y, i);
        dy = floor_shift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_val(i[4:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_val(i[4:0]));
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint tex_at(longint cell_len, longint idx, longint sheet);
      longint v;
      v = (cell_len * idx * 65536) / sheet;
      return v > 65536 ? 65536 : v;
    endfunction

    function logic [23:0] corner_pos(longint lx, longint ly, longint a, longint b,
                                     longint p);
      longint r;
      r = floor_shift(lx * a + ly * b + (longint'(1) << 30), 31) + p;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[23:0];
    endfunction

    function longint trunc_pos(longint p);
      return p >= 0 ? (p >>> 8) : -((-p) >>> 8);
    endfunction

    function longint eff(longint v, longint cap);
      if (v == 0) v = 1;
      return v > cap ? cap : v;
    endfunction

    // note an accepted request and queue its vertices
    function void note_request(req_t r);
      longint px, py, sw, sh, cw, ch, ft, ct, f, col, row, w, h, c, s, hx, hy, lx, ly;
      longint ul, ur, vt, vb;
      logic [15:0] ix, iy;
      logic [23:0] cx[4], cy[4];
      longint u4[4], v4[4];
      bit anim;
      vtx_t v;
      px = longint'(r.pos_x); py = longint'(r.pos_y);
      sw = eff(sheet_w, 8191); sh = eff(sheet_h, 8191);
      cw = eff(cell_w, 8191); ch = eff(cell_h, 8191);
      ft = eff(frames, 1024); ct = eff(cols, 1024);
      anim = ft > 1;
      ix = 16'(trunc_pos(px)); iy = 16'(trunc_pos(py));
      f = longint'(r.frame_index) % ft;
      if (have_prev && ix == prev_ix && iy == prev_iy && r.angle == prev_angle &&
          r.scale_factor == prev_scale && (!anim || f[9:0] == prev_frame))
        return;
      have_prev = 1; prev_ix = ix; prev_iy = iy;
      prev_angle = r.angle; prev_scale = r.scale_factor;
      if (anim) prev_frame = f[9:0];
      if (anim) begin
        col = f % ct; row = f / ct; w = cw; h = ch;
        ul = tex_at(cw, col, sw); ur = tex_at(cw, col + 1, sw);
        vt = tex_at(ch, row, sh); vb = tex_at(ch, row + 1, sh);
      end else begin
        w = sw; h = sh; ul = 0; ur = 65536; vt = 0; vb = 65536;
      end
      rotate(r.angle, c, s);
      hx = w * r.scale_factor; hy = h * r.scale_factor;
      for (int k = 0; k < 4; k++) begin
        lx = k[0] ? hx : -hx;
        ly = k[1] ? -hy : hy;
        cx[k] = corner_pos(lx, ly, c, -s, px);
        cy[k] = corner_pos(lx, ly, s, c, py);
        u4[k] = k[0] ? ur : ul;
        v4[k] = k[1] ? vb : vt;
      end
      for (int k = 0; k < VERTS_PER_QUAD; k++) begin
        v.vert_x = cx[corner_of(k[2:0])];
        v.vert_y = cy[corner_of(k[2:0])];
        v.vert_z = r.depth_in;
        v.tex_u = u4[corner_of(k[2:0])][16:0];
        v.tex_v = v4[corner_of(k[2:0])][16:0];
        v.last_vertex = (k == VERTS_PER_QUAD - 1);
        pending_vtx.push_back(v);
      end
    endfunction

    // compare one emitted vertex with the oldest expectation
    function void check_vertex(vtx_t got);
      vtx_t want;
      if (pending_vtx.size() == 0) begin
        $display("%0t unexpected vertex exp none got %h", $realtime, got);
        errors++;
        return;
      end
      want = pending_vtx.pop_front();
      if (want.vert_x !== got.vert_x)
        $display("%0t vert_x exp %0d got %0d", $realtime, want.vert_x, got.vert_x);
      if (want.vert_y !== got.vert_y)
        $display("%0t vert_y exp %0d got %0d", $realtime, want.vert_y, got.vert_y);
      if (want.vert_z !== got.vert_z)
        $display("%0t vert_z exp %0d got %0d", $realtime, want.vert_z, got.vert_z);
      if (want.tex_u !== got.tex_u)
        $display("%0t tex_u exp %0d got %0d", $realtime, want.tex_u, got.tex_u);
      if (want.tex_v !== got.tex_v)
        $display("%0t tex_v exp %0d got %0d", $realtime, want.tex_v, got.tex_v);
      if (want.last_vertex !== got.last_vertex)
        $display("%0t last_vertex exp %0b got %0b", $realtime, want.last_vertex,
                 got.last_vertex);
      if (want !== got) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_stall;
  req_t req = '0;
  logic vtx_valid;
  logic vtx_stall = 0;
  vtx_t vtx;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  quad_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  always #5 clk = ~clk;

  sprite_quad_vertex_setup u_dut (.*);

  // receiver: random stall or a long hold-off, check on acceptance
  always @(posedge clk) begin
    if (!rst && vtx_valid && !vtx_stall) sb.check_vertex(vtx);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      vtx_stall <= 1;
    end else begin
      vtx_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(idx, d);
    @(posedge clk);
  endtask

  // offer one request and hold it until taken
  task automatic send_request(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_valid <= 1; req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
    req_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending_vtx.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic req_t random_request();
    req_t r;
    r.pos_x = 24'($urandom); r.pos_y = 24'($urandom); r.depth_in = 16'($urandom);
    r.angle = 16'($urandom); r.frame_index = 16'($urandom);
    r.scale_factor = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1024));
    if ($urandom_range(3) == 0) begin
      r.pos_x = 24'($urandom_range(20000) - 10000);
      r.pos_y = 24'($urandom_range(20000) - 10000);
    end
    return r;
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    req_t r, prev;
    send_idle_pct = idle; recv_stall_pct = stall;
    prev = random_request();
    for (int i = 0; i < n; i++) begin
      r = random_request();
      // sometimes repeat the last request, maybe with sub-pixel moves
      if ($urandom_range(4) == 0) begin
        r = prev;
        r.pos_x[6:0] = 7'($urandom);
        r.depth_in = 16'($urandom);
      end
      send_request(r);
      prev = r;
    end
    drain();
  endtask

  initial begin
    #20ms;
    $display("tb_sprite_quad_vertex_setup NOT OK");
    $finish;
  end

  initial begin
    req_t r;
    sb.clear();
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, extremes, repeats, truncation toward zero
    r = '0;
    send_request(r);
    send_request(r);
    r.pos_x = 24'sh7FFFFF; r.pos_y = -24'sh800000; r.scale_factor = 16'hFFFF;
    r.angle = 16'h4000; r.depth_in = 16'sh7FFF; r.frame_index = 16'hFFFF;
    send_request(r);
    r.pos_x = -24'sh800000; r.pos_y = 24'sh7FFFFF; r.angle = 16'hC000;
    r.depth_in = -16'sh8000;
    send_request(r);
    r = '0; r.pos_x = -24'sd255; r.scale_factor = 16'h0100; r.angle = 16'h8000;
    send_request(r);
    r.pos_x = 24'sd255;
    send_request(r);
    r.angle = 16'hFFFF;
    send_request(r);
    drain();

    write_reg(REG_SHEET_W, 4096); write_reg(REG_SHEET_H, 4096);
    write_reg(REG_CELL_W, 4096); write_reg(REG_CELL_H, 4096);
    write_reg(REG_FRAMES, 1024); write_reg(REG_COLS, 1024);
    r.frame_index = 16'd1023;
    send_request(r);
    r.frame_index = 16'd2047;
    send_request(r);
    r.frame_index = 16'd5;
    send_request(r);
    drain();

    // zero registers and oversized counts; cells beyond the sheet
    write_reg(REG_SHEET_W, 0); write_reg(REG_SHEET_H, 32'h1FFF);
    write_reg(REG_CELL_W, 32'h1FFF); write_reg(REG_CELL_H, 0);
    write_reg(REG_FRAMES, 32'h7FF); write_reg(REG_COLS, 0);
    for (int i = 0; i < 4; i++) send_request(random_request());
    drain();

    // frame count one with a big sheet
    write_reg(REG_FRAMES, 1); write_reg(REG_SHEET_W, 8191);
    r.frame_index = 16'd7;
    send_request(r);
    r.frame_index = 16'd9;
    send_request(r);
    drain();

    // typical sprite sheet
    write_reg(REG_SHEET_W, 256); write_reg(REG_SHEET_H, 128);
    write_reg(REG_CELL_W, 32); write_reg(REG_CELL_H, 32);
    write_reg(REG_FRAMES, 32); write_reg(REG_COLS, 8);
    random_phase(14, 0, 0);

    // back pressure: receiver holds off while requests keep coming
    hold_off = 1500;
    random_phase(6, 0, 0);

    write_reg(REG_SHEET_W, 100); write_reg(REG_SHEET_H, 77);
    write_reg(REG_CELL_W, 30); write_reg(REG_CELL_H, 20);
    write_reg(REG_FRAMES, 17); write_reg(REG_COLS, 3);
    random_phase(25, 78, 0);
    random_phase(25, 0, 78);

    write_reg(REG_FRAMES, 1); write_reg(REG_SHEET_W, 64); write_reg(REG_SHEET_H, 48);
    random_phase(25, 24, 24);

    if (sb.errors == 0)
      $display("tb_sprite_quad_vertex_setup OK");
    else
      $display("tb_sprite_quad_vertex_setup NOT OK");
    $finish;
  end
endmodule

@@ sprite_quad_vertex_setup.f @@
+incdir+design
design/sqvs_pkg.sv
design/sqvs_regs.sv
design/sqvs_div.sv
design/sqvs_cordic.sv
design/sqvs_dp.sv
design/sqvs_ctrl.sv
design/sprite_quad_vertex_setup.sv
verif/tb_sprite_quad_vertex_setup.sv
